// ----- hdl/pts_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes of the priority task scheduler
package pts_pkg;

    localparam logic [2:0] FN_TICK       = 3'd0;
    localparam logic [2:0] FN_CREATE     = 3'd1;
    localparam logic [2:0] FN_DELAY      = 3'd2;
    localparam logic [2:0] FN_SEM_CREATE = 3'd3;
    localparam logic [2:0] FN_PEND       = 3'd4;
    localparam logic [2:0] FN_POST       = 3'd5;

    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_DELAYED = 2'd1;
    localparam logic [1:0] TS_WAITING = 2'd2;

    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_BAD_PRIO = 2'd1;
    localparam logic [1:0] RS_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  state;
        logic [15:0] delay;
        logic [4:0]  prio;
        logic [2:0]  sem;
    } t_task;

    typedef enum logic [1:0] {
        SC_NONE,
        SC_CREATE,
        SC_PEND,
        SC_POST
    } t_sem_op;

    typedef struct packed {
        t_sem_op     op;
        logic [2:0]  idx;
        logic [15:0] init;
        logic        opt;
    } t_sem_cmd;

    typedef struct packed {
        logic count_nz;
        logic waiting;
    } t_sem_view;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENT_RD,
        S_ENT_WB,
        S_CRE_WR,
        S_SCAN_RD,
        S_SCAN_WB,
        S_DONE
    } t_fsm;

endpackage

// ----- hdl/pts_task_mem.sv -----
`timescale 1ns / 1ps
// task table memory, one write port and one registered read port
module pts_task_mem #(
    parameter int MAX_TASKS = 16,
    parameter int TW        = 4
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [TW-1:0]   i_rd_addr,
    output pts_pkg::t_task  o_rd_data,
    input  logic            i_wr_en,
    input  logic [TW-1:0]   i_wr_addr,
    input  pts_pkg::t_task  i_wr_data
);
    import pts_pkg::*;

    t_task r_mem [MAX_TASKS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- hdl/pts_sem_regs.sv -----
`timescale 1ns / 1ps
// semaphore table: counts, pending marks and block options
module pts_sem_regs #(
    parameter int MAX_SEMS = 8,
    parameter int SW       = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pts_pkg::t_sem_cmd   i_cmd,
    output pts_pkg::t_sem_view  o_view,
    input  logic [2:0]          i_look_idx,
    output logic                o_look_waiting,
    output logic                o_look_nonblock
);
    import pts_pkg::*;

    logic [15:0]         r_count [MAX_SEMS];
    logic [MAX_SEMS-1:0] r_waiting;
    logic [MAX_SEMS-1:0] r_nonblock;
    logic                w_cmd_ok;
    logic                w_look_ok;
    logic [SW-1:0]       w_ci;
    logic [SW-1:0]       w_li;

    assign w_cmd_ok  = int'(i_cmd.idx) < MAX_SEMS;
    assign w_look_ok = int'(i_look_idx) < MAX_SEMS;
    assign w_ci      = SW'(i_cmd.idx);
    assign w_li      = SW'(i_look_idx);

    assign o_view.count_nz   = w_cmd_ok && (r_count[w_ci] != 16'd0);
    assign o_view.waiting    = w_cmd_ok && r_waiting[w_ci];
    assign o_look_waiting    = w_look_ok && r_waiting[w_li];
    assign o_look_nonblock   = w_look_ok && r_nonblock[w_li];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SEMS; k++) begin
                r_count[k] <= 16'd0;
            end
            r_waiting  <= '0;
            r_nonblock <= '0;
        end else if (w_cmd_ok) begin
            unique case (i_cmd.op)
                SC_CREATE: begin
                    r_count[w_ci]    <= i_cmd.init;
                    r_nonblock[w_ci] <= i_cmd.opt;
                    r_waiting[w_ci]  <= (i_cmd.init == 16'd0);
                end
                SC_PEND: begin
                    if (r_count[w_ci] != 16'd0) begin
                        r_count[w_ci] <= r_count[w_ci] - 16'd1;
                    end else begin
                        r_waiting[w_ci] <= 1'b1;
                    end
                end
                SC_POST: begin
                    if (r_waiting[w_ci]) begin
                        r_waiting[w_ci] <= 1'b0;
                    end else if (r_count[w_ci] != 16'hFFFF) begin
                        r_count[w_ci] <= r_count[w_ci] + 16'd1;
                    end
                end
                SC_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == SC_POST && w_cmd_ok && r_waiting[w_ci]) |=> !r_waiting[$past(w_ci)])
        else $error("post did not clear pending mark");

endmodule

// ----- hdl/priority_task_scheduler.sv -----
`timescale 1ns / 1ps
// top level of the priority task scheduler
// An item (tick, create task, delay, create semaphore, pend, post) is taken when
// start is high and busy low; exactly one result follows, shown for one cycle with
// o_done high, and the receiver cannot stall it. Create semaphore, post without a
// waiter, a pend that takes a count, a rejected create task and unused codes go
// straight to the result, create task after writing its new entry. A tick, a delay,
// a blocking pend or a post that releases waiters runs a scheduling pass over the
// task table held in a single-port-read memory: each created task is read, then
// modified and written back; when a task entry is rewritten first (delay, pend), it
// is read and written back the same way before the pass. An empty table gives no
// pass. busy stays high meanwhile.
module priority_task_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int MAX_SEMS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_task_index,
    input  logic [4:0]  i_priority_req,
    input  logic [15:0] i_ticks,
    input  logic [2:0]  i_sem_index,
    input  logic [15:0] i_init_count,
    input  logic        i_block_option,
    output logic        o_done,
    output logic [3:0]  o_ready_task,
    output logic [1:0]  o_status,
    output logic        o_acquired,
    output logic        o_rescheduled
);
    import pts_pkg::*;

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int SW = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;

    t_fsm        r_state, n_state;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_idx;
    logic [TW-1:0] r_best;
    logic [4:0]  r_best_prio;
    logic [TW-1:0] r_chosen;
    logic [TW-1:0] r_tix;
    logic [15:0] r_ticks;
    logic [4:0]  r_prio;
    logic [2:0]  r_six;
    logic        r_is_tick;
    logic        r_is_pend;
    logic [1:0]  r_status;
    logic        r_acq;
    logic        r_resched;

    logic        w_accept;
    logic        w_tix_ok;
    logic        w_six_ok;
    logic        w_prio_bad;
    logic        w_full;
    logic        w_pass_go;     // pass starts after this cycle if tasks exist
    logic        w_last;
    logic [1:0]  w_status;
    logic        w_acq;
    logic        w_resched;

    t_sem_cmd    w_sem_cmd;
    t_sem_view   w_sem_view;
    logic        w_look_waiting;
    logic        w_look_nonblock;

    logic        w_rd_en;
    logic [TW-1:0] w_rd_addr;
    t_task       w_rd_data;
    logic        w_wr_en;
    logic [TW-1:0] w_wr_addr;
    t_task       w_wr_data;
    t_task       w_upd;

    assign w_accept   = start && !busy;
    assign w_tix_ok   = int'(i_task_index) < MAX_TASKS;
    assign w_six_ok   = int'(i_sem_index) < MAX_SEMS;
    assign w_prio_bad = int'(i_priority_req) > MAX_TASKS;
    assign w_full     = r_total >= CW'(MAX_TASKS);
    assign w_last     = (r_idx + CW'(1)) == r_total;

    pts_task_mem #(.MAX_TASKS(MAX_TASKS), .TW(TW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    pts_sem_regs #(.MAX_SEMS(MAX_SEMS), .SW(SW)) u_sem (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_sem_cmd),
        .o_view          (w_sem_view),
        .i_look_idx      (w_rd_data.sem),
        .o_look_waiting  (w_look_waiting),
        .o_look_nonblock (w_look_nonblock)
    );

    // semaphore table changes at the accept edge, before any pass reads it
    always_comb begin
        w_sem_cmd.idx  = i_sem_index;
        w_sem_cmd.init = i_init_count;
        w_sem_cmd.opt  = i_block_option;
        w_sem_cmd.op   = SC_NONE;
        if (w_accept) begin
            priority case (i_func)
                FN_SEM_CREATE: w_sem_cmd.op = SC_CREATE;
                FN_PEND:       w_sem_cmd.op = SC_PEND;
                FN_POST:       w_sem_cmd.op = SC_POST;
                default:       w_sem_cmd.op = SC_NONE;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        w_pass_go = 1'b0;
        w_status  = RS_OK;
        w_acq     = 1'b0;
        w_resched = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DONE;
                    priority case (i_func)
                        FN_TICK: begin
                            w_pass_go = 1'b1;
                            w_resched = 1'b1;
                        end
                        FN_CREATE: begin
                            if (w_prio_bad) begin
                                w_status = RS_BAD_PRIO;
                            end else if (w_full) begin
                                w_status = RS_FULL;
                            end else begin
                                n_state = S_CRE_WR;
                            end
                        end
                        FN_DELAY: begin
                            w_resched = 1'b1;
                            if (w_tix_ok) begin
                                n_state = S_ENT_RD;
                            end else begin
                                w_pass_go = 1'b1;
                            end
                        end
                        FN_PEND: begin
                            if (w_six_ok) begin
                                if (w_sem_view.count_nz) begin
                                    w_acq = 1'b1;
                                end else begin
                                    w_resched = 1'b1;
                                    if (w_tix_ok) begin
                                        n_state = S_ENT_RD;
                                    end else begin
                                        w_pass_go = 1'b1;
                                    end
                                end
                            end
                        end
                        FN_POST: begin
                            if (w_sem_view.waiting) begin
                                w_pass_go = 1'b1;
                                w_resched = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ENT_RD:  n_state = S_ENT_WB;
            S_ENT_WB:  begin
                n_state   = S_DONE;
                w_pass_go = 1'b1;
            end
            S_CRE_WR:  n_state = S_DONE;
            S_SCAN_RD: n_state = S_SCAN_WB;
            S_SCAN_WB: n_state = w_last ? S_DONE : S_SCAN_RD;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
        // an empty table gives no pass at all
        if (w_pass_go && r_total != '0) begin
            n_state = S_SCAN_RD;
        end
    end

    // tick and release applied to one entry
    always_comb begin
        w_upd = w_rd_data;
        if (r_is_tick) begin
            if (w_rd_data.delay == 16'd0) begin
                if (w_rd_data.state == TS_DELAYED) begin
                    w_upd.state = TS_READY;
                end else if (w_rd_data.state == TS_WAITING && w_look_nonblock) begin
                    w_upd.state = TS_READY;
                end
            end else begin
                w_upd.delay = w_rd_data.delay - 16'd1;
            end
        end
        // waiters on a semaphore no longer pending go ready
        if (w_upd.state == TS_WAITING && int'(w_rd_data.sem) < MAX_SEMS
                && !w_look_waiting) begin
            w_upd.state = TS_READY;
        end
    end

    // memory port control
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx[TW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx[TW-1:0];
        w_wr_data = w_upd;
        busy      = (r_state != S_IDLE);
        o_done    = (r_state == S_DONE);
        unique case (r_state)
            S_ENT_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_tix;
            end
            S_ENT_WB: begin
                w_wr_en         = 1'b1;
                w_wr_addr       = r_tix;
                w_wr_data       = w_rd_data;
                w_wr_data.delay = r_ticks;
                if (r_is_pend) begin
                    w_wr_data.state = TS_WAITING;
                    w_wr_data.sem   = r_six;
                end else begin
                    w_wr_data.state = TS_DELAYED;
                end
            end
            S_CRE_WR: begin
                w_wr_en         = 1'b1;
                w_wr_addr       = r_total[TW-1:0];
                w_wr_data.state = TS_READY;
                w_wr_data.delay = 16'd0;
                w_wr_data.prio  = r_prio;
                w_wr_data.sem   = 3'd0;
            end
            S_SCAN_RD: begin
                w_rd_en = 1'b1;
            end
            S_SCAN_WB: begin
                w_wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_ready_task  = 4'(r_chosen);
    assign o_status      = r_status;
    assign o_acquired    = r_acq;
    assign o_rescheduled = r_resched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_chosen  <= '0;
            r_idx     <= '0;
            r_status  <= RS_OK;
            r_acq     <= 1'b0;
            r_resched <= 1'b0;
            r_is_tick <= 1'b0;
            r_is_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_tix     <= TW'(i_task_index);
                r_ticks   <= i_ticks;
                r_prio    <= i_priority_req;
                r_six     <= i_sem_index;
                r_is_tick <= (i_func == FN_TICK);
                r_is_pend <= (i_func == FN_PEND);
                r_status  <= w_status;
                r_acq     <= w_acq;
                r_resched <= w_resched;
            end
            if (w_pass_go) begin
                r_idx <= '0;
                if (r_total == '0) begin
                    r_chosen <= '0;
                end
            end
            if (r_state == S_CRE_WR) begin
                r_total <= r_total + CW'(1);
            end
            if (r_state == S_SCAN_WB) begin
                r_idx <= r_idx + CW'(1);
                if (r_idx == '0) begin
                    r_best      <= '0;
                    r_best_prio <= w_rd_data.prio;
                    if (w_last) begin
                        r_chosen <= '0;
                    end
                end else if (w_upd.state == TS_READY && r_best_prio > w_rd_data.prio) begin
                    r_best      <= r_idx[TW-1:0];
                    r_best_prio <= w_rd_data.prio;
                    if (w_last) begin
                        r_chosen <= r_idx[TW-1:0];
                    end
                end else if (w_last) begin
                    r_chosen <= r_best;
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("item accepted without going busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("no return to idle after result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_WB) |-> (r_idx < r_total))
        else $error("scan index beyond task count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_acquired && o_rescheduled))
        else $error("pend both acquired and blocked");

endmodule
